/* sv/random_access_set_engine_defines.svh */
// ----------------------------------------------------------------------------
// random_access_set_engine_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef RANDOM_ACCESS_SET_ENGINE_DEFINES_SVH
`define RANDOM_ACCESS_SET_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define RASE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rase check failed");

// next-cycle implication, sampled on clk, quiet in reset
`define RASE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rase check failed");

`endif

/* sv/rase_pkg.sv */
// ----------------------------------------------------------------------------
// rase_pkg
// shared constants and types of the random access set engine
// ----------------------------------------------------------------------------
package rase_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;
  localparam int RND_W     = 32;
  localparam int RND_CNT_W = $clog2(RND_W);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_EXISTS = 2'd2;
  localparam logic [1:0] OP_GET    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // one access bundle for the slot memory
  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [KEY_WIDTH-1:0] wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
  } ram_req_t;

endpackage

/* sv/random_access_set_engine.sv */
// ----------------------------------------------------------------------------
// random_access_set_engine
// set of distinct keys in a dense slot memory with swap remove
// ----------------------------------------------------------------------------
//
//  channel   ports                                  direction
//  in        in_valid in_stall in_op in_key         request in
//            in_random_value
//  out       out_valid out_stall out_status         request out
//            out_found out_element_out out_count
//
//  a request is taken only in idle, the next only after the result is handed off
//  insert, remove, exists: result set by the linear key search with one slot memory
//    read per cycle
//  get random: result set by the 32-step remainder unit, skipped on an empty set
//  reset (rst_n low, synchronous) empties the set, slots need no clearing
//  out_stall only holds the final hand-off; the next request is taken meanwhile
//
module random_access_set_engine
  import rase_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [31:0]          in_key,
  input  logic [RND_W-1:0]     in_random_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_found,
  output logic [31:0]          out_element_out,
  output logic [CNT_W-1:0]     out_count
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SEARCH  = 8'b0000_0010,
    S_RD_LAST = 8'b0000_0100,
    S_MOVE    = 8'b0000_1000,
    S_DIV     = 8'b0001_0000,
    S_RD_ELEM = 8'b0010_0000,
    S_ELEM    = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // request held for the whole operation
  logic [1:0]           op_r;
  logic [KEY_WIDTH-1:0] key_r;

  // occupancy, the only reset state besides control
  logic [CNT_W-1:0]     count_r;

  // search pipeline: issue address, compare the registered read in the next cycle
  logic [CNT_W-1:0]     issue_cnt_r;
  logic                 pend_r;
  logic [IDX_W-1:0]     pend_idx_r;
  logic [IDX_W-1:0]     pos_r;

  // pending result
  logic [1:0]           res_status_r;
  logic                 res_found_r;
  logic [31:0]          res_elem_r;

  // output register
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic                 out_found_r;
  logic [31:0]          out_elem_r;
  logic [CNT_W-1:0]     out_count_r;

  ram_req_t             ram_req;
  logic [KEY_WIDTH-1:0] rd_data;

  logic                 div_start;
  logic                 div_done;
  logic [IDX_W-1:0]     div_rem;

  logic                 accept;
  logic                 hit;
  logic                 miss;
  logic                 full;
  logic                 out_free;
  logic [CNT_W-1:0]     last;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign hit  = (state_r == S_SEARCH) && pend_r && (rd_data == key_r);
  assign miss = (state_r == S_SEARCH) && !pend_r && (issue_cnt_r == count_r);
  assign full = (count_r == CNT_W'(CAPACITY));
  assign last = count_r - 1'b1;

  // remainder only for a non-empty set
  assign div_start = accept && (in_op == OP_GET) && (count_r != '0);

  rase_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  rase_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_random_value),
    .divisor   (count_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // slot memory accesses per state
  always_comb begin
    ram_req = '0;
    case (state_r)
      S_SEARCH: begin
        ram_req.re    = (issue_cnt_r < count_r);
        ram_req.raddr = issue_cnt_r[IDX_W-1:0];
        // append on a miss when there is room
        if (miss && (op_r == OP_INSERT) && !full) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = count_r[IDX_W-1:0];
          ram_req.wdata = key_r;
        end
      end
      S_RD_LAST: begin
        // count already shrunk, so it points at the old last slot
        ram_req.re    = 1'b1;
        ram_req.raddr = count_r[IDX_W-1:0];
      end
      S_MOVE: begin
        // last element fills the hole
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        ram_req.wdata = rd_data;
      end
      S_RD_ELEM: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = div_rem;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op != OP_GET) begin
            state_nxt = S_SEARCH;
          end else if (count_r == '0) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          // removing a slot other than the last needs a move
          if ((op_r == OP_REMOVE) && (pend_idx_r != last[IDX_W-1:0])) begin
            state_nxt = S_RD_LAST;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (miss) begin
          state_nxt = S_FINISH;
        end
      end
      S_RD_LAST: state_nxt = S_MOVE;
      S_MOVE:    state_nxt = S_FINISH;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_RD_ELEM;
        end
      end
      S_RD_ELEM: state_nxt = S_ELEM;
      S_ELEM:    state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        pend_r <= 1'b0;
      end else if (state_r == S_SEARCH) begin
        pend_r <= (issue_cnt_r < count_r);
      end

      if ((state_r == S_SEARCH) && !hit && miss && (op_r == OP_INSERT) && !full) begin
        count_r <= count_r + 1'b1;
      end else if (hit && (op_r == OP_REMOVE)) begin
        count_r <= last;
      end

      if ((state_r == S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request, search and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_op;
      key_r        <= in_key[KEY_WIDTH-1:0];
      issue_cnt_r  <= '0;
      res_found_r  <= 1'b0;
      res_elem_r   <= '0;
      res_status_r <= ((in_op == OP_GET) && (count_r == '0)) ? ST_EMPTY : ST_OK;
    end

    if (state_r == S_SEARCH) begin
      if (issue_cnt_r < count_r) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      pend_idx_r <= issue_cnt_r[IDX_W-1:0];
      if (hit) begin
        pos_r       <= pend_idx_r;
        res_found_r <= 1'b1;
        if (op_r == OP_INSERT) begin
          res_status_r <= ST_DUP;
        end
      end else if (miss && (op_r == OP_INSERT) && full) begin
        res_status_r <= ST_FULL;
      end
    end

    if (state_r == S_ELEM) begin
      res_elem_r <= rd_data;
    end

    if ((state_r == S_FINISH) && out_free) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_elem_r   <= res_elem_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_element_out = out_elem_r;
  assign out_count       = out_count_r;

endmodule

/* sv/rase_slot_ram.sv */
// ----------------------------------------------------------------------------
// rase_slot_ram
// slot storage, one write and one registered read port
// ----------------------------------------------------------------------------
module rase_slot_ram
  import rase_pkg::*;
(
  input  logic                 clk,
  input  ram_req_t             req,
  output logic [KEY_WIDTH-1:0] rd_data
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

/* sv/rase_mod_unit.sv */
// ----------------------------------------------------------------------------
// rase_mod_unit
// restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rase_mod_unit
  import rase_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [IDX_W-1:0] remainder
);

  logic                 busy_r;
  logic                 done_r;
  logic [RND_CNT_W-1:0] bit_cnt_r;
  logic [RND_W-1:0]     dvd_r;
  logic [CNT_W-1:0]     dvs_r;
  logic [IDX_W-1:0]     rem_r;
  logic [CNT_W-1:0]     trial;
  logic [CNT_W-1:0]     diff;
  logic [IDX_W-1:0]     rem_nxt;

  // remainder stays below the divisor, so it fits the index width
  assign trial   = {rem_r, dvd_r[RND_W-1]};
  assign diff    = trial - dvs_r;
  assign rem_nxt = (trial >= dvs_r) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        bit_cnt_r <= '0;
        dvd_r     <= dividend;
        dvs_r     <= divisor;
        rem_r     <= '0;
      end else if (busy_r) begin
        rem_r     <= rem_nxt;
        dvd_r     <= {dvd_r[RND_W-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + 1'b1;
        if (bit_cnt_r == RND_CNT_W'(RND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* sv/rase_checker.sv */
// ----------------------------------------------------------------------------
// rase_checker
// port-level checks of the random access set engine, bound to the top level
// ----------------------------------------------------------------------------
`include "random_access_set_engine_defines.svh"

module rase_checker
  import rase_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       out_status,
  input logic             out_found,
  input logic [31:0]      out_element_out,
  input logic [CNT_W-1:0] out_count
);

  // occupancy never passes capacity
  `RASE_ASSERT_IMPLY(a_count_range, out_valid, out_count <= CNT_W'(CAPACITY))

  // empty report only with an empty set and no element
  `RASE_ASSERT_IMPLY(a_empty_set,
    out_valid && (out_status == ST_EMPTY),
    (out_count == '0) && (out_element_out == '0))

  // full report only at capacity and for an absent key
  `RASE_ASSERT_IMPLY(a_full_store,
    out_valid && (out_status == ST_FULL),
    (out_count == CNT_W'(CAPACITY)) && !out_found)

  // a stalled result holds
  `RASE_ASSERT_NEXT(a_out_hold,
    out_valid && out_stall,
    out_valid && $stable(out_count) && $stable(out_status))

  // a taken request stalls the request channel in the next cycle
  `RASE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

endmodule

bind random_access_set_engine rase_checker u_rase_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_element_out (out_element_out),
  .out_count       (out_count)
);
